### hdl/kwdd_pkg.sv
package kwdd_pkg;

  localparam int unsigned KW_MAX_LEN = 64;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned COST_W     = 4;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_TGT = 2'd0,
    OP_TYP = 2'd1,
    OP_RUN = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BADCHAR  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_COL_RD,
    S_COL_WR,
    S_ROW_RD,
    S_ROW_WR,
    S_ROW_ST,
    S_ROW_DIAG,
    S_ROW_LEFT,
    S_CELL_RD,
    S_CELL_EVAL,
    S_CELL_TR,
    S_TR_DIAG,
    S_TR_UP,
    S_TR_SUB,
    S_TR_LOOP,
    S_TR_ACC,
    S_TR_CMP,
    S_CELL_WR,
    S_FIN_RD,
    S_FIN,
    S_DONE
  } kwdd_state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] char_code;
  } kwdd_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } kwdd_out_t;

  typedef struct packed {
    logic       valid;
    logic       is_key;
    logic [1:0] row;
    logic [3:0] col;
    logic       hand;
    logic [1:0] finger;
  } key_t;

  function automatic key_t key_of(input logic [7:0] c);
    key_t       k;
    logic [1:0] r;
    logic [3:0] cl;
    logic       hit;
    hit = 1'b1;
    r   = 2'd0;
    cl  = 4'd0;
    case (c)
      "1": begin r = 2'd0; cl = 4'd0; end
      "2": begin r = 2'd0; cl = 4'd1; end
      "3": begin r = 2'd0; cl = 4'd2; end
      "4": begin r = 2'd0; cl = 4'd3; end
      "5": begin r = 2'd0; cl = 4'd4; end
      "6": begin r = 2'd0; cl = 4'd5; end
      "7": begin r = 2'd0; cl = 4'd6; end
      "8": begin r = 2'd0; cl = 4'd7; end
      "9": begin r = 2'd0; cl = 4'd8; end
      "0": begin r = 2'd0; cl = 4'd9; end
      "q": begin r = 2'd1; cl = 4'd0; end
      "w": begin r = 2'd1; cl = 4'd1; end
      "e": begin r = 2'd1; cl = 4'd2; end
      "r": begin r = 2'd1; cl = 4'd3; end
      "t": begin r = 2'd1; cl = 4'd4; end
      "y": begin r = 2'd1; cl = 4'd5; end
      "u": begin r = 2'd1; cl = 4'd6; end
      "i": begin r = 2'd1; cl = 4'd7; end
      "o": begin r = 2'd1; cl = 4'd8; end
      "p": begin r = 2'd1; cl = 4'd9; end
      "a": begin r = 2'd2; cl = 4'd0; end
      "s": begin r = 2'd2; cl = 4'd1; end
      "d": begin r = 2'd2; cl = 4'd2; end
      "f": begin r = 2'd2; cl = 4'd3; end
      "g": begin r = 2'd2; cl = 4'd4; end
      "h": begin r = 2'd2; cl = 4'd5; end
      "j": begin r = 2'd2; cl = 4'd6; end
      "k": begin r = 2'd2; cl = 4'd7; end
      "l": begin r = 2'd2; cl = 4'd8; end
      ";": begin r = 2'd2; cl = 4'd9; end
      "z": begin r = 2'd3; cl = 4'd0; end
      "x": begin r = 2'd3; cl = 4'd1; end
      "c": begin r = 2'd3; cl = 4'd2; end
      "v": begin r = 2'd3; cl = 4'd3; end
      "b": begin r = 2'd3; cl = 4'd4; end
      "n": begin r = 2'd3; cl = 4'd5; end
      "m": begin r = 2'd3; cl = 4'd6; end
      ",": begin r = 2'd3; cl = 4'd7; end
      ".": begin r = 2'd3; cl = 4'd8; end
      default: hit = 1'b0;
    endcase
    k.valid  = hit || (c == CHAR_SPACE);
    k.is_key = hit;
    k.row    = r;
    k.col    = cl;
    k.hand   = hit && (cl > 4'd4);
    case (cl)
      4'd0, 4'd9: k.finger = 2'd0;
      4'd1, 4'd8: k.finger = 2'd1;
      4'd2, 4'd7: k.finger = 2'd2;
      default:    k.finger = 2'd3;
    endcase
    return k;
  endfunction

  // chebyshev distance of two keys
  function automatic logic [COST_W-1:0] key_dist(input key_t a, input key_t b);
    logic [3:0] dr;
    logic [3:0] dc;
    dr = (a.row > b.row) ? 4'(a.row - b.row) : 4'(b.row - a.row);
    dc = (a.col > b.col) ? (a.col - b.col) : (b.col - a.col);
    return (dr > dc) ? dr : dc;
  endfunction

  function automatic logic [COST_W-1:0] ins_cost(input logic [7:0] ins, input logic has_prev,
                                                 input logic [7:0] pc, input logic has_next,
                                                 input logic [7:0] nc);
    key_t              ki;
    key_t              kp;
    key_t              kn;
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] cand;
    ki   = key_of(ins);
    kp   = key_of(pc);
    kn   = key_of(nc);
    best = 4'd6;
    cand = 4'd6;
    if (has_prev && pc == ins) best = 4'd1;
    if (has_next && nc == ins) best = 4'd1;
    if (ins == CHAR_SPACE) begin
      if (has_prev && kp.is_key && best > 4'd2) best = 4'd2;
    end else begin
      if (has_prev && kp.is_key) begin
        cand = (kp.hand == ki.hand) ? key_dist(kp, ki) : 4'd3;
        if (cand < best) best = cand;
      end
      if (has_next && kn.is_key) begin
        cand = (kn.hand == ki.hand) ? key_dist(ki, kn) : 4'd3;
        if (cand < best) best = cand;
      end
    end
    return best;
  endfunction

  function automatic logic [COST_W-1:0] del_cost(input logic [7:0] dc, input logic has_prev,
                                                 input logic [7:0] pc);
    key_t kd;
    key_t kp;
    kd = key_of(dc);
    kp = key_of(pc);
    if (has_prev && pc == dc) return 4'd1;
    if (dc == CHAR_SPACE) return 4'd3;
    if (has_prev && kp.is_key && kd.is_key && kp.hand == kd.hand) return 4'd2;
    return 4'd6;
  endfunction

  function automatic logic [COST_W-1:0] sub_cost(input logic [7:0] a, input logic [7:0] b);
    key_t ka;
    key_t kb;
    ka = key_of(a);
    kb = key_of(b);
    if (a == b) return 4'd0;
    if (a == CHAR_SPACE || b == CHAR_SPACE) return 4'd6;
    if (ka.hand == kb.hand) return key_dist(ka, kb);
    if (ka.finger == kb.finger) return 4'd1;
    return 4'd5;
  endfunction

  function automatic logic [COST_W-1:0] trans_cost(input logic [7:0] a, input logic [7:0] b);
    if (a == CHAR_SPACE || b == CHAR_SPACE) return 4'd3;
    return (key_of(a).hand != key_of(b).hand) ? 4'd1 : 4'd2;
  endfunction

endpackage

### hdl/keyboard_weighted_damerau_distance.sv
// keyboard-weighted damerau-levenshtein distance engine
// input channel (in_valid_i / in_stall_o / in_data_i): one beat per op.
//   append target or typed char: taken back to back, no result.
//   run: computes the weighted distance of the collected strings, then clears them.
//   op code 3 is taken and dropped.
// output channel (out_valid_o / out_stall_i / out_data_o): one beat per run,
//   carrying distance and status (ok, bad character, string too long).
// a run with an error goes straight to the done state and loads its result once the
//   output register is free. otherwise the engine fills the first column, then the
//   first row, then each cell row by row (only when both strings are nonempty), and
//   reads the final cell last; a cell where a transposition applies also walks the
//   typed chars between the swapped pair. the single matrix read port sets the pace.
// in_stall_o is high for the whole run; appends are taken while a result
//   waits on a stalled output, and a finished run holds until the output
//   register is free.
// reset empties both strings and the output register; the ram contents are
//   not cleared. the last-row table is cleared at the start of each error-free run.
module keyboard_weighted_damerau_distance #(
  parameter int unsigned MAX_LEN = kwdd_pkg::KW_MAX_LEN
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  kwdd_pkg::kwdd_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output kwdd_pkg::kwdd_out_t out_data_o
);
  import kwdd_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_LEN + 1);
  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned DIM = MAX_LEN + 1;
  localparam int unsigned MW  = $clog2(DIM * DIM);

  logic              tgt_we, typ_we, mat_we, lr_clr, lr_we;
  logic [7:0]        wdata;
  logic [AW-1:0]     waddr, tgt_ra, tgt_rb, typ_ra, typ_rb;
  logic [7:0]        tgt_da, tgt_db, typ_da, typ_db;
  logic [MW-1:0]     mat_wa, mat_ra;
  logic [DIST_W-1:0] mat_wd, mat_rd;
  logic [7:0]        lr_wa, lr_ra;
  logic [CW-1:0]     lr_wd, lr_rd;

  kwdd_char_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_tgt_ram (
    .clk_i, .we_i(tgt_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(tgt_ra), .raddr_b_i(tgt_rb), .rdata_a_o(tgt_da), .rdata_b_o(tgt_db)
  );

  kwdd_char_ram #(.DEPTH(MAX_LEN), .AW(AW)) u_typ_ram (
    .clk_i, .we_i(typ_we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_a_i(typ_ra), .raddr_b_i(typ_rb), .rdata_a_o(typ_da), .rdata_b_o(typ_db)
  );

  kwdd_mat_ram #(.DEPTH(DIM * DIM), .AW(MW)) u_mat_ram (
    .clk_i, .we_i(mat_we), .waddr_i(mat_wa), .wdata_i(mat_wd),
    .raddr_i(mat_ra), .rdata_o(mat_rd)
  );

  kwdd_last_row #(.W(CW)) u_last_row (
    .clk_i, .rst_ni, .clr_i(lr_clr), .we_i(lr_we), .waddr_i(lr_wa), .wdata_i(lr_wd),
    .raddr_i(lr_ra), .rdata_o(lr_rd)
  );

  kwdd_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .wdata_o(wdata), .tgt_we_o(tgt_we), .typ_we_o(typ_we), .waddr_o(waddr),
    .tgt_raddr_a_o(tgt_ra), .tgt_raddr_b_o(tgt_rb), .tgt_rdata_a_i(tgt_da),
    .tgt_rdata_b_i(tgt_db),
    .typ_raddr_a_o(typ_ra), .typ_raddr_b_o(typ_rb), .typ_rdata_a_i(typ_da),
    .typ_rdata_b_i(typ_db),
    .mat_we_o(mat_we), .mat_waddr_o(mat_wa), .mat_wdata_o(mat_wd),
    .mat_raddr_o(mat_ra), .mat_rdata_i(mat_rd),
    .lr_clr_o(lr_clr), .lr_we_o(lr_we), .lr_waddr_o(lr_wa), .lr_wdata_o(lr_wd),
    .lr_raddr_o(lr_ra), .lr_rdata_i(lr_rd)
  );
endmodule

### hdl/kwdd_char_ram.sv
module kwdd_char_ram #(
  parameter int unsigned DEPTH = kwdd_pkg::KW_MAX_LEN,
  parameter int unsigned AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [7:0]    rdata_a_o,
  output logic [7:0]    rdata_b_o
);
  logic [7:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end
endmodule

### hdl/kwdd_mat_ram.sv
module kwdd_mat_ram #(
  parameter int unsigned DEPTH = 4225,
  parameter int unsigned AW    = 13
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [kwdd_pkg::DIST_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [kwdd_pkg::DIST_W-1:0] rdata_o
);
  import kwdd_pkg::*;

  logic [DIST_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### hdl/kwdd_last_row.sv
module kwdd_last_row #(
  parameter int unsigned W = 7
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         clr_i,
  input  logic         we_i,
  input  logic [7:0]   waddr_i,
  input  logic [W-1:0] wdata_i,
  input  logic [7:0]   raddr_i,
  output logic [W-1:0] rdata_o
);
  logic [W-1:0] mem_q [256];
  logic [255:0] vld_q;
  logic [W-1:0] rd_q;
  logic         rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q  <= 1'b0;
    end else begin
      if (clr_i) vld_q <= '0;
      else if (we_i) vld_q[waddr_i] <= 1'b1;
      rv_q <= vld_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rd_q <= mem_q[raddr_i];
  end

  // entries not written since the last clear read as zero
  assign rdata_o = rv_q ? rd_q : '0;
endmodule

### hdl/kwdd_ctrl.sv
module kwdd_ctrl #(
  parameter int unsigned MAX_LEN = kwdd_pkg::KW_MAX_LEN,
  localparam int unsigned CW  = $clog2(MAX_LEN + 1),
  localparam int unsigned AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1,
  localparam int unsigned DIM = MAX_LEN + 1,
  localparam int unsigned MW  = $clog2(DIM * DIM)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  kwdd_pkg::kwdd_in_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output kwdd_pkg::kwdd_out_t         out_data_o,
  output logic [7:0]                  wdata_o,
  output logic                        tgt_we_o,
  output logic                        typ_we_o,
  output logic [AW-1:0]               waddr_o,
  output logic [AW-1:0]               tgt_raddr_a_o,
  output logic [AW-1:0]               tgt_raddr_b_o,
  input  logic [7:0]                  tgt_rdata_a_i,
  input  logic [7:0]                  tgt_rdata_b_i,
  output logic [AW-1:0]               typ_raddr_a_o,
  output logic [AW-1:0]               typ_raddr_b_o,
  input  logic [7:0]                  typ_rdata_a_i,
  input  logic [7:0]                  typ_rdata_b_i,
  output logic                        mat_we_o,
  output logic [MW-1:0]               mat_waddr_o,
  output logic [kwdd_pkg::DIST_W-1:0] mat_wdata_o,
  output logic [MW-1:0]               mat_raddr_o,
  input  logic [kwdd_pkg::DIST_W-1:0] mat_rdata_i,
  output logic                        lr_clr_o,
  output logic                        lr_we_o,
  output logic [7:0]                  lr_waddr_o,
  output logic [CW-1:0]               lr_wdata_o,
  output logic [7:0]                  lr_raddr_o,
  input  logic [CW-1:0]               lr_rdata_i
);
  import kwdd_pkg::*;

  kwdd_state_e       state_q, state_d;
  logic [CW-1:0]     n_q, n_d, m_q, m_d;
  logic              ovf_q, ovf_d, bad_q, bad_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d, k_q, k_d, db_q, db_d, i1_q, i1_d;
  logic [DIST_W-1:0] acc_q, acc_d, diag_q, diag_d, left_q, left_d, up_q, up_d;
  logic [SUM_W-1:0]  best_q, best_d, c4_q, c4_d;
  logic [7:0]        tc_q, tc_d, yc_q, yc_d;
  logic [COST_W-1:0] del_row_q, del_row_d;
  kwdd_out_t         res_q, res_d, out_q;
  logic              out_valid_q, out_load;

  logic [CW-1:0]     i_m1, i_m2, j_m1, j_m2, k_m1, lr_m1, db_m1;
  logic [COST_W-1:0] c_del_col, c_ins_row, c_del_row, c_ins_cell, c_sub, c_ins_tr, c_trans;
  logic [SUM_W-1:0]  b_sub, b_del, b_ins, b_min;
  logic [DIST_W-1:0] cell_val;
  key_t              in_key;

  function automatic logic [MW-1:0] mat_addr(input logic [CW-1:0] row, input logic [CW-1:0] col);
    return MW'(row) * MW'(DIM) + MW'(col);
  endfunction

  assign i_m1  = i_q - CW'(1);
  assign i_m2  = i_q - CW'(2);
  assign j_m1  = j_q - CW'(1);
  assign j_m2  = j_q - CW'(2);
  assign k_m1  = k_q - CW'(1);
  assign lr_m1 = lr_rdata_i - CW'(1);
  assign db_m1 = db_q - CW'(1);

  assign in_key     = key_of(in_data_i.char_code);
  assign c_del_col  = del_cost(tgt_rdata_a_i, i_q != '0, tgt_rdata_b_i);
  assign c_ins_row  = ins_cost(typ_rdata_a_i, j_q != '0, typ_rdata_b_i, n_q != '0, tgt_rdata_b_i);
  assign c_del_row  = del_cost(tgt_rdata_a_i, i_q > CW'(1), tgt_rdata_b_i);
  assign c_ins_cell = ins_cost(typ_rdata_a_i, j_q > CW'(1), typ_rdata_b_i, 1'b1, tc_q);
  assign c_sub      = sub_cost(tc_q, typ_rdata_a_i);
  assign c_ins_tr   = ins_cost(typ_rdata_a_i, 1'b1, typ_rdata_b_i, 1'b1, yc_q);
  assign c_trans    = trans_cost(yc_q, tc_q);

  assign b_sub = SUM_W'(diag_q) + SUM_W'(c_sub);
  assign b_del = SUM_W'(mat_rdata_i) + SUM_W'(del_row_q);
  assign b_ins = SUM_W'(left_q) + SUM_W'(c_ins_cell);
  always_comb begin
    b_min = b_sub;
    if (b_del < b_min) b_min = b_del;
    if (b_ins < b_min) b_min = b_ins;
  end

  assign cell_val = (best_q > SUM_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : best_q[DIST_W-1:0];

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign wdata_o     = in_data_i.char_code;

  always_comb begin
    state_d   = state_q;
    n_d       = n_q;
    m_d       = m_q;
    ovf_d     = ovf_q;
    bad_d     = bad_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    db_d      = db_q;
    i1_d      = i1_q;
    acc_d     = acc_q;
    diag_d    = diag_q;
    left_d    = left_q;
    up_d      = up_q;
    best_d    = best_q;
    c4_d      = c4_q;
    tc_d      = tc_q;
    yc_d      = yc_q;
    del_row_d = del_row_q;
    res_d     = res_q;
    out_load  = 1'b0;

    tgt_we_o      = 1'b0;
    typ_we_o      = 1'b0;
    waddr_o       = '0;
    tgt_raddr_a_o = i_q[AW-1:0];
    tgt_raddr_b_o = i_m1[AW-1:0];
    typ_raddr_a_o = j_q[AW-1:0];
    typ_raddr_b_o = j_m1[AW-1:0];
    mat_we_o      = 1'b0;
    mat_waddr_o   = mat_addr(i_q, j_q);
    mat_wdata_o   = acc_q;
    mat_raddr_o   = mat_addr(i_q, j_q);
    lr_clr_o      = 1'b0;
    lr_we_o       = 1'b0;
    lr_waddr_o    = tc_q;
    lr_wdata_o    = i_q;
    lr_raddr_o    = typ_rdata_a_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.op)
            OP_TGT: begin
              if (n_q < CW'(MAX_LEN)) begin
                tgt_we_o = 1'b1;
                waddr_o  = n_q[AW-1:0];
                n_d      = n_q + CW'(1);
                if (!in_key.valid) bad_d = 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_TYP: begin
              if (m_q < CW'(MAX_LEN)) begin
                typ_we_o = 1'b1;
                waddr_o  = m_q[AW-1:0];
                m_d      = m_q + CW'(1);
                if (!in_key.valid) bad_d = 1'b1;
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_RUN: begin
              res_d.distance = '0;
              if (ovf_q) begin
                res_d.status = ST_OVERFLOW;
                state_d      = S_DONE;
              end else if (bad_q) begin
                res_d.status = ST_BADCHAR;
                state_d      = S_DONE;
              end else begin
                lr_clr_o = 1'b1;
                i_d      = '0;
                acc_d    = '0;
                state_d  = S_COL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      // first column: running sum of deletion costs
      S_COL_RD: state_d = S_COL_WR;
      S_COL_WR: begin
        mat_we_o    = 1'b1;
        mat_waddr_o = mat_addr(i_q, '0);
        if (i_q == n_q) begin
          j_d     = '0;
          acc_d   = '0;
          state_d = S_ROW_RD;
        end else begin
          acc_d   = acc_q + DIST_W'(c_del_col);
          i_d     = i_q + CW'(1);
          state_d = S_COL_RD;
        end
      end
      // first row: running sum of insertion costs against target char 0
      S_ROW_RD: begin
        tgt_raddr_b_o = '0;
        state_d       = S_ROW_WR;
      end
      S_ROW_WR: begin
        mat_we_o    = 1'b1;
        mat_waddr_o = mat_addr('0, j_q);
        if (j_q == m_q) begin
          if (n_q == '0 || m_q == '0) begin
            state_d = S_FIN_RD;
          end else begin
            i_d     = CW'(1);
            state_d = S_ROW_ST;
          end
        end else begin
          acc_d   = acc_q + DIST_W'(c_ins_row);
          j_d     = j_q + CW'(1);
          state_d = S_ROW_RD;
        end
      end
      S_ROW_ST: begin
        tgt_raddr_a_o = i_m1[AW-1:0];
        tgt_raddr_b_o = i_m2[AW-1:0];
        mat_raddr_o   = mat_addr(i_m1, '0);
        j_d           = CW'(1);
        db_d          = '0;
        state_d       = S_ROW_DIAG;
      end
      S_ROW_DIAG: begin
        tc_d        = tgt_rdata_a_i;
        del_row_d   = c_del_row;
        diag_d      = mat_rdata_i;
        mat_raddr_o = mat_addr(i_q, '0);
        state_d     = S_ROW_LEFT;
      end
      S_ROW_LEFT: begin
        left_d  = mat_rdata_i;
        state_d = S_CELL_RD;
      end
      S_CELL_RD: begin
        typ_raddr_a_o = j_m1[AW-1:0];
        typ_raddr_b_o = j_m2[AW-1:0];
        mat_raddr_o   = mat_addr(i_m1, j_q);
        state_d       = S_CELL_EVAL;
      end
      S_CELL_EVAL: begin
        yc_d    = typ_rdata_a_i;
        up_d    = mat_rdata_i;
        best_d  = b_min;
        state_d = S_CELL_TR;
      end
      S_CELL_TR: begin
        if (lr_rdata_i != '0 && db_q != '0) begin
          i1_d        = lr_rdata_i;
          mat_raddr_o = mat_addr(lr_m1, db_m1);
          state_d     = S_TR_DIAG;
        end else begin
          state_d = S_CELL_WR;
        end
      end
      // deletions between the two rows come from the first column difference
      S_TR_DIAG: begin
        c4_d        = SUM_W'(mat_rdata_i) + SUM_W'(c_trans);
        mat_raddr_o = mat_addr(i_m1, '0);
        state_d     = S_TR_UP;
      end
      S_TR_UP: begin
        c4_d        = c4_q + SUM_W'(mat_rdata_i);
        mat_raddr_o = mat_addr(i1_q, '0);
        state_d     = S_TR_SUB;
      end
      S_TR_SUB: begin
        c4_d    = c4_q - SUM_W'(mat_rdata_i);
        k_d     = db_q;
        state_d = S_TR_LOOP;
      end
      S_TR_LOOP: begin
        typ_raddr_a_o = k_q[AW-1:0];
        typ_raddr_b_o = k_m1[AW-1:0];
        state_d       = (k_q < j_m1) ? S_TR_ACC : S_TR_CMP;
      end
      S_TR_ACC: begin
        c4_d    = c4_q + SUM_W'(c_ins_tr);
        k_d     = k_q + CW'(1);
        state_d = S_TR_LOOP;
      end
      S_TR_CMP: begin
        if (c4_q < best_q) best_d = c4_q;
        state_d = S_CELL_WR;
      end
      S_CELL_WR: begin
        mat_we_o    = 1'b1;
        mat_wdata_o = cell_val;
        left_d      = cell_val;
        diag_d      = up_q;
        if (tc_q == yc_q) db_d = j_q;
        if (j_q == m_q) begin
          lr_we_o = 1'b1;
          if (i_q == n_q) begin
            state_d = S_FIN_RD;
          end else begin
            i_d     = i_q + CW'(1);
            state_d = S_ROW_ST;
          end
        end else begin
          j_d     = j_q + CW'(1);
          state_d = S_CELL_RD;
        end
      end
      S_FIN_RD: begin
        mat_raddr_o = mat_addr(n_q, m_q);
        state_d     = S_FIN;
      end
      S_FIN: begin
        res_d.distance = mat_rdata_i;
        res_d.status   = ST_OK;
        state_d        = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          n_d      = '0;
          m_d      = '0;
          ovf_d    = 1'b0;
          bad_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      m_q         <= '0;
      ovf_q       <= 1'b0;
      bad_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      m_q     <= m_d;
      ovf_q   <= ovf_d;
      bad_q   <= bad_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    k_q       <= k_d;
    db_q      <= db_d;
    i1_q      <= i1_d;
    acc_q     <= acc_d;
    diag_q    <= diag_d;
    left_q    <= left_d;
    up_q      <= up_d;
    best_q    <= best_d;
    c4_q      <= c4_d;
    tc_q      <= tc_d;
    yc_q      <= yc_d;
    del_row_q <= del_row_d;
    res_q     <= res_d;
    if (out_load) out_q <= res_q;
  end
endmodule

### hdl/kwdd_checker.sv
module kwdd_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input kwdd_pkg::kwdd_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input kwdd_pkg::kwdd_out_t out_data_o
);
  import kwdd_pkg::*;

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // error results carry zero distance
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.distance == '0)
    else $error("error result with nonzero distance");

  // a run beat makes the input side busy
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.op == OP_RUN |=> in_stall_o)
    else $error("input not stalled after run beat");

  // appends keep the input side open
  a_append_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_data_i.op == OP_TGT || in_data_i.op == OP_TYP)
    |=> !in_stall_o)
    else $error("input stalled after append beat");

  // a new result only shows up at the end of a run
  a_out_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared outside a run");
endmodule

bind keyboard_weighted_damerau_distance kwdd_checker u_kwdd_checker (.*);

### dv/keyboard_weighted_damerau_distance_test.sv
`timescale 1ns / 100ps

module keyboard_weighted_damerau_distance_test;
  import kwdd_pkg::*;

  localparam logic [1:0] OP_NOP     = 2'd3;
  localparam int         MAX_CHARS  = 64;
  localparam int         IDLE_LIMIT = 2000000;
  localparam int         RAND_ITEMS = 1350;
  localparam int         DRAIN_CYC  = 64;

  typedef struct {
    bit valid;
    bit is_key;
    int row;
    int col;
  } key_pos_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  kwdd_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  kwdd_out_t out_data;

  keyboard_weighted_damerau_distance DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  string kb_rows[4] = '{"1234567890", "qwertyuiop", "asdfghjkl;", "zxcvbnm,."};
  string alphabet   = "1234567890qwertyuiopasdfghjkl;zxcvbnm,. ";

  // predictor state
  byte unsigned tgt_chars[MAX_CHARS];
  byte unsigned typ_chars[MAX_CHARS];
  int           tgt_len;
  int           typ_len;
  bit           too_long;
  int           cost[MAX_CHARS+1][MAX_CHARS+1];
  int           last_row[256];

  kwdd_out_t    expected_results[$];
  int           mismatches = 0;
  int           burst_left = 0;
  int           items_sent = 0;
  int           idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic key_pos_t locate_key(byte unsigned c);
    key_pos_t k;
    k = '{0, 0, 0, 0};
    if (c == CHAR_SPACE) k.valid = 1;
    for (int r = 0; r < 4; r++) begin
      for (int cl = 0; cl < kb_rows[r].len(); cl++) begin
        if (kb_rows[r][cl] == c) k = '{1, 1, r, cl};
      end
    end
    return k;
  endfunction

  function automatic int hand_of(key_pos_t k);
    return (k.is_key && k.col > 4) ? 1 : 0;
  endfunction

  function automatic int finger_of(key_pos_t k);
    if (k.col == 0 || k.col == 9) return 0;
    if (k.col == 1 || k.col == 8) return 1;
    if (k.col == 2 || k.col == 7) return 2;
    return 3;
  endfunction

  function automatic int key_gap(key_pos_t a, key_pos_t b);
    int dr;
    int dc;
    dr = (a.row > b.row) ? a.row - b.row : b.row - a.row;
    dc = (a.col > b.col) ? a.col - b.col : b.col - a.col;
    return (dr > dc) ? dr : dc;
  endfunction

  function automatic int insert_weight(int i, int j);
    byte unsigned ch;
    byte unsigned pc;
    byte unsigned nc;
    bit           has_prev;
    bit           has_next;
    key_pos_t     ki;
    key_pos_t     kp;
    key_pos_t     kn;
    int           best;
    int           cand;
    ch       = typ_chars[j];
    has_prev = j > 0;
    has_next = i < tgt_len;
    pc       = has_prev ? typ_chars[j-1] : 8'd0;
    nc       = has_next ? tgt_chars[i] : 8'd0;
    ki       = locate_key(ch);
    kp       = locate_key(pc);
    kn       = locate_key(nc);
    best     = 6;
    if (has_prev && pc == ch) best = 1;
    if (has_next && nc == ch) best = 1;
    if (ch == CHAR_SPACE) begin
      if (has_prev && kp.is_key && best > 2) best = 2;
    end else begin
      if (has_prev && kp.is_key) begin
        cand = (hand_of(kp) == hand_of(ki)) ? key_gap(kp, ki) : 3;
        if (cand < best) best = cand;
      end
      if (has_next && kn.is_key) begin
        cand = (hand_of(kn) == hand_of(ki)) ? key_gap(ki, kn) : 3;
        if (cand < best) best = cand;
      end
    end
    return best;
  endfunction

  function automatic int delete_weight(int i);
    byte unsigned ch;
    byte unsigned pc;
    key_pos_t     kd;
    key_pos_t     kp;
    ch = tgt_chars[i];
    pc = (i > 0) ? tgt_chars[i-1] : 8'd0;
    kd = locate_key(ch);
    kp = locate_key(pc);
    if (i > 0 && pc == ch) return 1;
    if (ch == CHAR_SPACE) return 3;
    if (i > 0 && kp.is_key && kd.is_key && hand_of(kp) == hand_of(kd)) return 2;
    return 6;
  endfunction

  function automatic int replace_weight(byte unsigned a, byte unsigned b);
    key_pos_t ka;
    key_pos_t kb;
    ka = locate_key(a);
    kb = locate_key(b);
    if (a == b) return 0;
    if (a == CHAR_SPACE || b == CHAR_SPACE) return 6;
    if (hand_of(ka) == hand_of(kb)) return key_gap(ka, kb);
    if (finger_of(ka) == finger_of(kb)) return 1;
    return 5;
  endfunction

  function automatic int swap_weight(byte unsigned a, byte unsigned b);
    if (a == CHAR_SPACE || b == CHAR_SPACE) return 3;
    return (hand_of(locate_key(a)) != hand_of(locate_key(b))) ? 1 : 2;
  endfunction

  function automatic int edit_distance();
    int           acc;
    int           db;
    int           i1;
    int           j1;
    int           best;
    int           c4;
    byte unsigned tc;
    byte unsigned yc;
    for (int c = 0; c < 256; c++) last_row[c] = 0;
    acc = 0;
    for (int i = 0; i <= tgt_len; i++) begin
      cost[i][0] = acc;
      if (i < tgt_len) acc += delete_weight(i);
    end
    acc = 0;
    for (int j = 0; j <= typ_len; j++) begin
      cost[0][j] = acc;
      if (j < typ_len) acc += insert_weight(0, j);
    end
    for (int i = 1; i <= tgt_len; i++) begin
      db = 0;
      tc = tgt_chars[i-1];
      for (int j = 1; j <= typ_len; j++) begin
        yc = typ_chars[j-1];
        i1 = last_row[yc];
        j1 = db;
        if (tc == yc) db = j;
        best = cost[i-1][j-1] + replace_weight(tc, yc);
        if (cost[i-1][j] + delete_weight(i-1) < best) best = cost[i-1][j] + delete_weight(i-1);
        if (cost[i][j-1] + insert_weight(i-1, j-1) < best)
          best = cost[i][j-1] + insert_weight(i-1, j-1);
        if (i1 > 0 && j1 > 0 && tgt_chars[i1-1] == yc && tc == typ_chars[j1-1]) begin
          c4 = cost[i1-1][j1-1];
          for (int k = i1; k + 1 < i; k++) c4 += delete_weight(k);
          for (int k = j1; k + 1 < j; k++) c4 += insert_weight(i1 - 1, k);
          c4 += swap_weight(tgt_chars[i1-1], tc);
          if (c4 < best) best = c4;
        end
        cost[i][j] = (best > 65535) ? 65535 : best;
      end
      last_row[tc] = i;
    end
    return cost[tgt_len][typ_len];
  endfunction

  task automatic predict_beat(logic [1:0] op, byte unsigned ch);
    kwdd_out_t res;
    bit        bad;
    bad = 0;
    if (op == OP_TGT) begin
      if (tgt_len < MAX_CHARS) tgt_chars[tgt_len++] = ch;
      else too_long = 1;
    end else if (op == OP_TYP) begin
      if (typ_len < MAX_CHARS) typ_chars[typ_len++] = ch;
      else too_long = 1;
    end else if (op == OP_RUN) begin
      res.distance = '0;
      res.status   = ST_OK;
      if (too_long) begin
        res.status = ST_OVERFLOW;
      end else begin
        for (int k = 0; k < tgt_len; k++) if (!locate_key(tgt_chars[k]).valid) bad = 1;
        for (int k = 0; k < typ_len; k++) if (!locate_key(typ_chars[k]).valid) bad = 1;
        if (bad) res.status = ST_BADCHAR;
        else res.distance = 16'(edit_distance());
      end
      expected_results.insert(expected_results.size(), res);
      tgt_len  = 0;
      typ_len  = 0;
      too_long = 0;
    end
  endtask

  // one input beat, with bursts and gaps on the sender side
  task automatic send_beat(logic [1:0] op, byte unsigned ch);
    int gap;
    bit took;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= kwdd_in_t'{op: op, char_code: ch};
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    predict_beat(op, ch);
    if (op != OP_NOP) items_sent++;
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic byte unsigned pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 8'($urandom_range(0, 255));
    if (r < 30) return alphabet[$urandom_range(0, 3) == 0 ? 39 : $urandom_range(20, 22)];
    return alphabet[$urandom_range(0, 39)];
  endfunction

  task automatic send_string(logic [1:0] op, string s);
    for (int k = 0; k < s.len(); k++) send_beat(op, s[k]);
  endtask

  task automatic send_pair(string tgt, string typ);
    send_string(OP_TGT, tgt);
    send_string(OP_TYP, typ);
    send_beat(OP_RUN, 8'd0);
  endtask

  task automatic test_directed();
    send_beat(OP_RUN, 8'hff);
    send_pair("a", "");
    send_pair("", " ");
    send_pair("ab", "ba");
    send_pair("a p", "ap ");
    send_pair("q", "0");
    send_beat(OP_NOP, 8'h55);
    send_pair("1", "~");
    send_beat(OP_TGT, 8'h00);
    send_beat(OP_RUN, 8'd0);
    send_pair("mm.", "m.;");
  endtask

  task automatic test_overflow();
    for (int k = 0; k <= MAX_CHARS; k++) send_beat(OP_TGT, pick_char());
    send_beat(OP_TYP, 8'h80);
    send_beat(OP_RUN, 8'd0);
    for (int k = 0; k <= MAX_CHARS; k++) send_beat(OP_TYP, alphabet[$urandom_range(0, 39)]);
    send_beat(OP_RUN, 8'd0);
  endtask

  task automatic test_full_length();
    for (int k = 0; k < MAX_CHARS; k++) send_beat(OP_TGT, alphabet[$urandom_range(0, 39)]);
    for (int k = 0; k < MAX_CHARS; k++) send_beat(OP_TYP, alphabet[$urandom_range(0, 39)]);
    send_beat(OP_RUN, 8'd0);
    for (int k = 0; k < MAX_CHARS; k++) send_beat(OP_TYP, alphabet[$urandom_range(20, 23)]);
    send_beat(OP_RUN, 8'd0);
  endtask

  // half the time a target and a lightly edited copy of it as typed text
  task automatic test_random_pairs();
    byte unsigned tw[$];
    byte unsigned yw[$];
    byte unsigned tmp;
    int           n;
    int           p;
    int           pause_at;
    pause_at = RAND_ITEMS / 2;
    while (items_sent < RAND_ITEMS) begin
      tw.delete();
      n = $urandom_range(0, 8);
      for (int k = 0; k < n; k++) tw.insert(tw.size(), pick_char());
      if ($urandom_range(0, 1) == 0) begin
        yw = tw;
        repeat ($urandom_range(1, 2)) begin
          p = (yw.size() > 0) ? $urandom_range(0, yw.size() - 1) : 0;
          case ($urandom_range(0, 3))
            0: if (p + 1 < yw.size()) begin
              tmp = yw[p]; yw[p] = yw[p+1]; yw[p+1] = tmp;
            end
            1: if (yw.size() > 0) yw[p] = pick_char();
            2: if (yw.size() > 0) yw.delete(p);
            default: yw.insert(p, pick_char());
          endcase
        end
      end else begin
        yw.delete();
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) yw.insert(yw.size(), pick_char());
      end
      while (tw.size() + yw.size() > 0) begin
        if ($urandom_range(0, 29) == 0) send_beat(OP_NOP, 8'($urandom_range(0, 255)));
        if (yw.size() == 0 || (tw.size() > 0 && $urandom_range(0, 1) == 0))
          send_beat(OP_TGT, tw.pop_front());
        else
          send_beat(OP_TYP, yw.pop_front());
      end
      send_beat(OP_RUN, 8'($urandom_range(0, 255)));
      if (items_sent >= pause_at) begin
        pause_at = RAND_ITEMS * 4;
        in_valid <= 1'b0;
        @(posedge clk);
        wait_results_drained();
      end
    end
  endtask

  initial begin
    tgt_len  = 0;
    typ_len  = 0;
    too_long = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_full_length();
    test_random_pairs();
    in_valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYC) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // receiver stall pattern: free, sparse, or heavy phases
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 400);
    end
    stall_left--;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 99) < 30);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  // outputs are sampled on the falling edge before the edge that takes the beat
  always @(negedge clk) begin
    kwdd_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: distance %0d status %0d",
                   out_data.distance, out_data.status);
      end else begin
        want = expected_results.pop_front();
        if (want.distance !== out_data.distance || want.status !== out_data.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected distance %0d status %0d, got %0d status %0d",
                     want.distance, want.status, out_data.distance, out_data.status);
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule
